// File: design/rpc_pkg.sv
// ----------------------------------------------------------------------------
// rpc_pkg: shared types and constants for point rotation about a center
// Field widths, angle constants, the CORDIC arctangent table and the gain
// correction used by the pipeline cells and the output stage.
// ----------------------------------------------------------------------------
package rpc_pkg;

    localparam int ANGLE_W          = 16;
    localparam int COORD_W          = 24;
    localparam int ATAN_LEN         = 24;
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int EXTRA_FRAC       = 6;

    // working widths: coordinates with 14 fractional bits, angle in Q30
    localparam int CW = 33;
    localparam int ZW = 33;
    localparam int KW = 31;
    localparam int AW = 18;

    localparam logic signed [AW-1:0] ANG_HALF_PI = 18'sd12868;
    localparam logic signed [AW-1:0] ANG_PI      = 18'sd25736;
    localparam logic signed [AW-1:0] ANG_TWO_PI  = 18'sd51472;

    localparam logic signed [COORD_W-1:0] COORD_MAX = 24'sh7FFFFF;
    localparam logic signed [COORD_W-1:0] COORD_MIN = 24'sh800000;

    localparam logic [29:0] ATAN_Q30 [ATAN_LEN] = '{
        30'd843314856, 30'd497837829, 30'd263043836, 30'd133525158,
        30'd67021686,  30'd33543515,  30'd16775850,  30'd8388437,
        30'd4194282,   30'd2097149,   30'd1048575,   30'd524287,
        30'd262143,    30'd131071,    30'd65535,     30'd32767,
        30'd16383,     30'd8191,      30'd4095,      30'd2047,
        30'd1023,      30'd511,       30'd255,       30'd127
    };

    typedef struct packed {
        logic signed [CW-1:0]      x;
        logic signed [CW-1:0]      y;
        logic signed [ZW-1:0]      z;
        logic signed [COORD_W-1:0] cx;
        logic signed [COORD_W-1:0] cy;
    } t_stage;

    // Q30 gain correction for a given number of stages, evaluated at elaboration
    function automatic logic [KW-1:0] gain_q30(input int steps);
        longint k;
        k = 64'sd652039507;
        for (int n = 8; n < steps && n < ATAN_LEN; n++) begin
            k = k - (k >>> (2 * n + 1));
        end
        return k[KW-1:0];
    endfunction

endpackage

// File: design/rpc_in_if.sv
// ----------------------------------------------------------------------------
// rpc_in_if: input channel of the point rotation block
// Valid/ready channel carrying the angle, the center and the point.
// ----------------------------------------------------------------------------
interface rpc_in_if;
    import rpc_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [ANGLE_W-1:0] rot_angle;
    logic signed [COORD_W-1:0] center_x;
    logic signed [COORD_W-1:0] center_y;
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;

    modport source (
        output valid, rot_angle, center_x, center_y, point_x, point_y,
        input  ready
    );
    modport sink (
        input  valid, rot_angle, center_x, center_y, point_x, point_y,
        output ready
    );
endinterface

// File: design/rpc_out_if.sv
// ----------------------------------------------------------------------------
// rpc_out_if: output channel of the point rotation block
// Valid/ready channel carrying the rotated point and the saturation flag.
// ----------------------------------------------------------------------------
interface rpc_out_if;
    import rpc_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] rotated_x;
    logic signed [COORD_W-1:0] rotated_y;
    logic                      clipped;

    modport source (
        output valid, rotated_x, rotated_y, clipped,
        input  ready
    );
    modport sink (
        input  valid, rotated_x, rotated_y, clipped,
        output ready
    );
endinterface

// File: design/rpc_prep.sv
// ----------------------------------------------------------------------------
// rpc_prep: entry stage of the rotation pipeline
// Forms the offset from the center, wraps the angle to +-pi and pre-turns
// by 90 degrees so the CORDIC cells only see angles within +-pi/2.
// ----------------------------------------------------------------------------
module rpc_prep (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  logic                              i_valid,
    input  logic signed [rpc_pkg::ANGLE_W-1:0] i_rot_angle,
    input  logic signed [rpc_pkg::COORD_W-1:0] i_center_x,
    input  logic signed [rpc_pkg::COORD_W-1:0] i_center_y,
    input  logic signed [rpc_pkg::COORD_W-1:0] i_point_x,
    input  logic signed [rpc_pkg::COORD_W-1:0] i_point_y,
    output logic                              o_valid,
    output rpc_pkg::t_stage                   o_stage
);
    import rpc_pkg::*;

    logic signed [COORD_W:0] w_dx;
    logic signed [COORD_W:0] w_dy;
    logic signed [CW-1:0]    w_x0;
    logic signed [CW-1:0]    w_y0;
    logic signed [AW-1:0]    w_a_in;
    logic signed [AW-1:0]    w_a_wrap;
    logic signed [AW-1:0]    w_a;
    t_stage                  n_stage;
    t_stage                  r_stage;
    logic                    r_valid;

    always_comb begin
        w_dx = (COORD_W+1)'(i_point_x) - (COORD_W+1)'(i_center_x);
        w_dy = (COORD_W+1)'(i_point_y) - (COORD_W+1)'(i_center_y);
        w_x0 = CW'(w_dx) <<< EXTRA_FRAC;
        w_y0 = CW'(w_dy) <<< EXTRA_FRAC;

        w_a_in = AW'(i_rot_angle);
        if (w_a_in > ANG_PI) begin
            w_a_wrap = w_a_in - ANG_TWO_PI;
        end else if (w_a_in < -ANG_PI) begin
            w_a_wrap = w_a_in + ANG_TWO_PI;
        end else begin
            w_a_wrap = w_a_in;
        end

        n_stage.cx = i_center_x;
        n_stage.cy = i_center_y;
        if (w_a_wrap > ANG_HALF_PI) begin
            n_stage.x = -w_y0;
            n_stage.y = w_x0;
            w_a       = w_a_wrap - ANG_HALF_PI;
        end else if (w_a_wrap < -ANG_HALF_PI) begin
            n_stage.x = w_y0;
            n_stage.y = -w_x0;
            w_a       = w_a_wrap + ANG_HALF_PI;
        end else begin
            n_stage.x = w_x0;
            n_stage.y = w_y0;
            w_a       = w_a_wrap;
        end
        // angle from Q13 to Q30
        n_stage.z = ZW'(w_a) <<< 17;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_stage <= n_stage;
        end
    end

    assign o_valid = r_valid;
    assign o_stage = r_stage;

endmodule

// File: design/rpc_cell.sv
// ----------------------------------------------------------------------------
// rpc_cell: one CORDIC rotation cell
// Turns the vector by +-atan(2^-IDX) toward zero residual angle and hands
// the result to the next cell.
// ----------------------------------------------------------------------------
module rpc_cell #(
    parameter int IDX = 0
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  rpc_pkg::t_stage i_stage,
    output logic            o_valid,
    output rpc_pkg::t_stage o_stage
);
    import rpc_pkg::*;

    logic signed [CW-1:0] w_xs;
    logic signed [CW-1:0] w_ys;
    logic signed [ZW-1:0] w_atan;
    t_stage               n_stage;
    t_stage               r_stage;
    logic                 r_valid;

    always_comb begin
        w_xs   = $signed(i_stage.y) >>> IDX;
        w_ys   = $signed(i_stage.x) >>> IDX;
        w_atan = $signed(ZW'(ATAN_Q30[IDX]));
        n_stage = i_stage;
        if (!i_stage.z[ZW-1]) begin
            n_stage.x = i_stage.x - w_xs;
            n_stage.y = i_stage.y + w_ys;
            n_stage.z = i_stage.z - w_atan;
        end else begin
            n_stage.x = i_stage.x + w_xs;
            n_stage.y = i_stage.y - w_ys;
            n_stage.z = i_stage.z + w_atan;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_stage <= n_stage;
        end
    end

    assign o_valid = r_valid;
    assign o_stage = r_stage;

endmodule

// File: design/rpc_post.sv
// ----------------------------------------------------------------------------
// rpc_post: gain correction and output register
// Multiplies by the CORDIC gain, rounds back to 8 fractional bits, adds the
// center and saturates to the coordinate range.
// ----------------------------------------------------------------------------
module rpc_post #(
    parameter int STEPS = rpc_pkg::CORDIC_STEPS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  logic                              i_valid,
    input  rpc_pkg::t_stage                   i_stage,
    output logic                              o_valid,
    output logic signed [rpc_pkg::COORD_W-1:0] o_rotated_x,
    output logic signed [rpc_pkg::COORD_W-1:0] o_rotated_y,
    output logic                              o_clipped
);
    import rpc_pkg::*;

    localparam int PW = CW + KW + 1;
    localparam int RS = 36;
    localparam int RW = PW - RS;
    localparam int SW = RW + 1;
    localparam logic [KW-1:0]          GAIN       = gain_q30(STEPS);
    localparam logic signed [PW-1:0]   ROUND_HALF = PW'(1) <<< (RS - 1);

    logic signed [PW-1:0]      r_prod_x;
    logic signed [PW-1:0]      r_prod_y;
    logic signed [COORD_W-1:0] r_cx;
    logic signed [COORD_W-1:0] r_cy;
    logic                      r_mvalid;

    logic signed [PW-1:0]      w_bx;
    logic signed [PW-1:0]      w_by;
    logic signed [SW-1:0]      w_sx;
    logic signed [SW-1:0]      w_sy;
    logic signed [COORD_W-1:0] n_rx;
    logic signed [COORD_W-1:0] n_ry;
    logic                      n_clip;
    logic signed [COORD_W-1:0] r_rx;
    logic signed [COORD_W-1:0] r_ry;
    logic                      r_clip;
    logic                      r_valid;

    // multiply stage
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod_x <= PW'($signed(i_stage.x)) * PW'($signed({1'b0, GAIN}));
            r_prod_y <= PW'($signed(i_stage.y)) * PW'($signed({1'b0, GAIN}));
            r_cx     <= i_stage.cx;
            r_cy     <= i_stage.cy;
        end
    end

    // round half up, add center back, saturate
    always_comb begin
        w_bx = (r_prod_x + ROUND_HALF) >>> RS;
        w_by = (r_prod_y + ROUND_HALF) >>> RS;
        w_sx = SW'($signed(w_bx[RW-1:0])) + SW'(r_cx);
        w_sy = SW'($signed(w_by[RW-1:0])) + SW'(r_cy);
        n_clip = 1'b0;
        if (w_sx > SW'(COORD_MAX)) begin
            n_rx   = COORD_MAX;
            n_clip = 1'b1;
        end else if (w_sx < SW'(COORD_MIN)) begin
            n_rx   = COORD_MIN;
            n_clip = 1'b1;
        end else begin
            n_rx = w_sx[COORD_W-1:0];
        end
        if (w_sy > SW'(COORD_MAX)) begin
            n_ry   = COORD_MAX;
            n_clip = 1'b1;
        end else if (w_sy < SW'(COORD_MIN)) begin
            n_ry   = COORD_MIN;
            n_clip = 1'b1;
        end else begin
            n_ry = w_sy[COORD_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rx   <= n_rx;
            r_ry   <= n_ry;
            r_clip <= n_clip;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mvalid <= 1'b0;
            r_valid  <= 1'b0;
        end else if (i_en) begin
            r_mvalid <= i_valid;
            r_valid  <= r_mvalid;
        end
    end

    assign o_valid     = r_valid;
    assign o_rotated_x = r_rx;
    assign o_rotated_y = r_ry;
    assign o_clipped   = r_clip;

endmodule

// File: design/rotate_point_about_center_top.sv
// ----------------------------------------------------------------------------
// rotate_point_about_center_top: rotate a point about a center by an angle
// Fixed-point CORDIC pipeline with gain correction and saturation.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries one beat per point: rot_angle (Q2.13 radians), the center
//   and the point (24-bit, 8 fractional bits). o_out returns one beat per
//   input beat, in order: the rotated point and a clipped flag that is set
//   when either coordinate saturated.
//   Throughput is one beat per cycle while the receiver takes beats. The
//   stages in order: one entry stage, one register per CORDIC cell, the gain
//   multiply stage and the output register.
//   The whole pipeline advances together; it moves whenever the output
//   register is empty or being taken. While the receiver stalls with a
//   beat waiting, i_in.ready is low and every stage holds.
//   Reset clears all valid bits; nothing is in flight afterwards and no
//   clearing pass is needed.
// ----------------------------------------------------------------------------
module rotate_point_about_center_top #(
    parameter int CORDIC_STEPS = rpc_pkg::CORDIC_STEPS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rpc_in_if.sink    i_in,
    rpc_out_if.source o_out
);
    import rpc_pkg::*;

    localparam int NCELL = (CORDIC_STEPS < ATAN_LEN) ? CORDIC_STEPS : ATAN_LEN;

    logic   w_en;
    logic   w_valid [NCELL+1];
    t_stage w_stage [NCELL+1];

    // advance when the output register is free or its beat is taken
    assign w_en       = !o_out.valid || o_out.ready;
    assign i_in.ready = w_en;

    rpc_prep u_prep (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (w_en),
        .i_valid     (i_in.valid),
        .i_rot_angle (i_in.rot_angle),
        .i_center_x  (i_in.center_x),
        .i_center_y  (i_in.center_y),
        .i_point_x   (i_in.point_x),
        .i_point_y   (i_in.point_y),
        .o_valid     (w_valid[0]),
        .o_stage     (w_stage[0])
    );

    for (genvar g = 0; g < NCELL; g++) begin : g_cell
        rpc_cell #(
            .IDX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_valid[g]),
            .i_stage (w_stage[g]),
            .o_valid (w_valid[g+1]),
            .o_stage (w_stage[g+1])
        );
    end

    rpc_post #(
        .STEPS (NCELL)
    ) u_post (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (w_en),
        .i_valid     (w_valid[NCELL]),
        .i_stage     (w_stage[NCELL]),
        .o_valid     (o_out.valid),
        .o_rotated_x (o_out.rotated_x),
        .o_rotated_y (o_out.rotated_y),
        .o_clipped   (o_out.clipped)
    );

`ifndef SYNTH
    a_stall_blocks_input: assert property (@(posedge i_clk)
        (o_out.valid && !o_out.ready) |-> !i_in.ready)
        else $error("input taken while output beat is stalled");

    a_clip_means_saturated: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.clipped) |->
            (o_out.rotated_x == COORD_MAX || o_out.rotated_x == COORD_MIN ||
             o_out.rotated_y == COORD_MAX || o_out.rotated_y == COORD_MIN))
        else $error("clipped flag set without a saturated coordinate");

    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out.valid)
        else $error("output valid right after reset");
`endif

endmodule

// File: test/rotate_point_about_center_top_check.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rotate_point_about_center_top_check: scoreboard for the point rotation block
// Watches both channels. Every input beat is turned into the rotated point
// that the fixed-point CORDIC should give, and every output beat is compared
// field by field with the oldest one still due.
// ----------------------------------------------------------------------------
module rotate_point_about_center_top_check #(
    parameter int CORDIC_STEPS = rpc_pkg::CORDIC_STEPS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    rpc_in_if    in_ch,
    rpc_out_if   out_ch,
    output int   o_mismatches,
    output int   o_pending
);
    import rpc_pkg::*;

    localparam int     STAGES    = (CORDIC_STEPS < ATAN_LEN) ? CORDIC_STEPS : ATAN_LEN;
    localparam longint GAIN_AT_8 = 64'sd652039507;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic                      clipped;
    } t_rotated_point;

    t_rotated_point points_due[$];

    // Q30 gain correction for STAGES CORDIC cells
    function automatic longint stage_gain();
        longint k;
        k = GAIN_AT_8;
        for (int n = 8; n < STAGES; n++) begin
            k = k - (k >>> (2 * n + 1));
        end
        return k;
    endfunction

    function automatic longint clamp_coord(input longint v, inout bit clip);
        if (v > longint'(COORD_MAX)) begin
            clip = 1'b1;
            return longint'(COORD_MAX);
        end
        if (v < longint'(COORD_MIN)) begin
            clip = 1'b1;
            return longint'(COORD_MIN);
        end
        return v;
    endfunction

    function automatic t_rotated_point rotate_about_center(
        input logic signed [ANGLE_W-1:0] ang,
        input logic signed [COORD_W-1:0] cx,
        input logic signed [COORD_W-1:0] cy,
        input logic signed [COORD_W-1:0] px,
        input logic signed [COORD_W-1:0] py
    );
        longint         a, x, y, z, t, xs, ys, k, rx, ry;
        bit             clip;
        t_rotated_point res;
        clip = 1'b0;
        a = longint'(ang);
        x = (longint'(px) - longint'(cx)) * (64'sd1 <<< EXTRA_FRAC);
        y = (longint'(py) - longint'(cy)) * (64'sd1 <<< EXTRA_FRAC);
        // wrap into +-pi, then fold quadrants beyond +-pi/2 with an exact turn
        if (a > longint'(ANG_PI))  a = a - longint'(ANG_TWO_PI);
        if (a < -longint'(ANG_PI)) a = a + longint'(ANG_TWO_PI);
        if (a > longint'(ANG_HALF_PI)) begin
            t = x; x = -y; y = t;
            a = a - longint'(ANG_HALF_PI);
        end else if (a < -longint'(ANG_HALF_PI)) begin
            t = x; x = y; y = -t;
            a = a + longint'(ANG_HALF_PI);
        end
        z = a * (64'sd1 <<< 17);
        for (int i = 0; i < STAGES; i++) begin
            xs = y >>> i;
            ys = x >>> i;
            if (z >= 0) begin
                x = x - xs; y = y + ys; z = z - longint'(ATAN_Q30[i]);
            end else begin
                x = x + xs; y = y - ys; z = z + longint'(ATAN_Q30[i]);
            end
        end
        k  = stage_gain();
        rx = ((x * k + (64'sd1 <<< 35)) >>> 36) + longint'(cx);
        ry = ((y * k + (64'sd1 <<< 35)) >>> 36) + longint'(cy);
        rx = clamp_coord(rx, clip);
        ry = clamp_coord(ry, clip);
        res.x       = rx[COORD_W-1:0];
        res.y       = ry[COORD_W-1:0];
        res.clipped = clip;
        return res;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("%0t: %s: got %0d, want %0d", $realtime, what, got, want);
        o_mismatches++;
    endtask

    initial begin
        o_mismatches = 0;
        o_pending    = 0;
    end

    always @(posedge i_clk) begin
        t_rotated_point want;
        if (i_rst_n) begin
            if (out_ch.valid && out_ch.ready) begin
                if (points_due.size() == 0) begin
                    report_mismatch("output beat with nothing due",
                        longint'(out_ch.rotated_x), longint'(0));
                end else begin
                    want = points_due.pop_front();
                    if (out_ch.rotated_x !== want.x)
                        report_mismatch("rotated_x", longint'(out_ch.rotated_x),
                            longint'(want.x));
                    if (out_ch.rotated_y !== want.y)
                        report_mismatch("rotated_y", longint'(out_ch.rotated_y),
                            longint'(want.y));
                    if (out_ch.clipped !== want.clipped)
                        report_mismatch("clipped", longint'(out_ch.clipped),
                            longint'(want.clipped));
                end
            end
            if (in_ch.valid && in_ch.ready) begin
                points_due.push_back(rotate_about_center(in_ch.rot_angle, in_ch.center_x,
                    in_ch.center_y, in_ch.point_x, in_ch.point_y));
            end
            o_pending = points_due.size();
        end
    end

endmodule

// File: test/rotate_point_about_center_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rotate_point_about_center_top_test: testbench for point rotation about a center
// Drives directed corner points (angle wrap, quadrant folds, saturation) and
// then random points in bursts against a receiver that stalls, once for a
// long stretch. The checker predicts every result; the verdict is given here.
// ----------------------------------------------------------------------------
module rotate_point_about_center_top_test;
    import rpc_pkg::*;

    localparam int STEPS      = CORDIC_STEPS_DEF;
    localparam int LATENCY    = ((STEPS < ATAN_LEN) ? STEPS : ATAN_LEN) + 3;
    localparam int N_RANDOM   = 1400;
    localparam int HOLD_AFTER = 600;
    localparam int HOLD_LEN   = 150;

    typedef enum int {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_PERIODIC} t_rx_mode;

    typedef struct packed {
        logic signed [ANGLE_W-1:0] ang;
        logic signed [COORD_W-1:0] cx;
        logic signed [COORD_W-1:0] cy;
        logic signed [COORD_W-1:0] px;
        logic signed [COORD_W-1:0] py;
    } t_point_job;

    logic i_clk;
    logic i_rst_n;
    int   mismatches;
    int   pending;
    int   n_sent;

    rpc_in_if  in_ch ();
    rpc_out_if out_ch ();

    rotate_point_about_center_top #(.CORDIC_STEPS(STEPS)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    rotate_point_about_center_top_check #(.CORDIC_STEPS(STEPS)) checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .in_ch        (in_ch),
        .out_ch       (out_ch),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    initial begin
        #3_000_000;
        $display("rotate_point_about_center_top: mismatch");
        $finish;
    end

    // present one beat and hold it until taken; returns at a falling edge
    task automatic send_point(input t_point_job job);
        in_ch.valid     = 1'b1;
        in_ch.rot_angle = job.ang;
        in_ch.center_x  = job.cx;
        in_ch.center_y  = job.cy;
        in_ch.point_x   = job.px;
        in_ch.point_y   = job.py;
        do @(posedge i_clk); while (!in_ch.ready);
        n_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_coords(input int a, input int cx, input int cy, input int px,
                               input int py);
        t_point_job job;
        job.ang = a[ANGLE_W-1:0];
        job.cx  = cx[COORD_W-1:0];
        job.cy  = cy[COORD_W-1:0];
        job.px  = px[COORD_W-1:0];
        job.py  = py[COORD_W-1:0];
        send_point(job);
        in_ch.valid = 1'b0;
    endtask

    function automatic t_point_job random_job();
        t_point_job job;
        int         pick;
        int         a;
        pick = $urandom_range(99);
        if (pick < 80) begin
            a = int'($urandom_range(51472)) - 25736;
        end else if (pick < 92) begin
            // straddle the quadrant folds and the wrap points
            case ($urandom_range(3))
                0: a = 12868;
                1: a = -12868;
                2: a = 25736;
                default: a = -25736;
            endcase
            a = a + int'($urandom_range(4)) - 2;
        end else begin
            a = $urandom;
        end
        job.ang = a[ANGLE_W-1:0];
        pick = $urandom_range(99);
        if (pick < 40) begin
            job.cx = COORD_W'($urandom);
            job.cy = COORD_W'($urandom);
            job.px = COORD_W'($urandom);
            job.py = COORD_W'($urandom);
        end else if (pick < 80) begin
            job.cx = COORD_W'(int'($urandom_range(1 << 23)) - (1 << 22));
            job.cy = COORD_W'(int'($urandom_range(1 << 23)) - (1 << 22));
            job.px = job.cx + COORD_W'(int'($urandom_range(1 << 17)) - (1 << 16));
            job.py = job.cy + COORD_W'(int'($urandom_range(1 << 17)) - (1 << 16));
        end else begin
            job.cx = COORD_W'(int'($urandom_range(4096)) - 2048);
            job.cy = COORD_W'(int'($urandom_range(4096)) - 2048);
            job.px = COORD_W'(int'($urandom_range(4096)) - 2048);
            job.py = COORD_W'(int'($urandom_range(4096)) - 2048);
        end
        return job;
    endfunction

    // receiver: stall pattern changes after each span of random length; one long hold
    initial begin : rx_stall
        t_rx_mode mode;
        int       span;
        int       cyc;
        bit       held;
        out_ch.ready = 1'b1;
        held = 1'b0;
        cyc  = 0;
        forever begin
            mode = t_rx_mode'($urandom_range(3));
            span = $urandom_range(300, 40);
            repeat (span) begin
                @(negedge i_clk);
                cyc++;
                if (!held && n_sent >= HOLD_AFTER) begin
                    held = 1'b1;
                    out_ch.ready = 1'b0;
                    repeat (HOLD_LEN) @(negedge i_clk);
                end
                case (mode)
                    RX_OPEN:  out_ch.ready = 1'b1;
                    RX_LIGHT: out_ch.ready = ($urandom_range(99) >= 25);
                    RX_HEAVY: out_ch.ready = ($urandom_range(99) >= 60);
                    default:  out_ch.ready = (cyc % 3 != 0);
                endcase
            end
        end
    end

    initial begin : stimulus
        int burst;
        int gap;
        int left;
        n_sent          = 0;
        i_rst_n         = 1'b0;
        in_ch.valid     = 1'b0;
        in_ch.rot_angle = '0;
        in_ch.center_x  = '0;
        in_ch.center_y  = '0;
        in_ch.point_x   = '0;
        in_ch.point_y   = '0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // directed corners
        send_coords(0, 0, 0, 0, 0);
        send_coords(0, 0, 0, 256000, 0);
        send_coords(12868, 0, 0, 256000, 128000);
        send_coords(-12868, 0, 0, 256000, 128000);
        send_coords(12869, 1000, -1000, 300000, 5000);
        send_coords(-12869, 1000, -1000, 300000, 5000);
        send_coords(12867, -500, 700, -90000, 40000);
        send_coords(25736, 0, 0, 100000, -200000);
        send_coords(-25736, 0, 0, 100000, -200000);
        send_coords(25737, 10, 20, 70000, 30000);
        send_coords(-25737, 10, 20, 70000, 30000);
        send_coords(32767, 0, 0, 8388607, 8388607);
        send_coords(-32768, 0, 0, -8388608, -8388608);
        // half turn about the top corner throws the far corner out of range
        send_coords(25736, 8388607, 8388607, -8388608, -8388608);
        send_coords(25736, -8388608, -8388608, 8388607, 8388607);
        send_coords(0, -8388608, -8388608, 8388607, 8388607);
        send_coords(6434, 0, 0, 8388607, 8388607);
        send_coords(-6434, 0, 0, 8388607, -8388608);
        send_coords(-1, 0, 0, -1, -1);
        send_coords(1, 0, 0, -8388608, -8388608);
        send_coords(20000, 8388607, 8388607, 8388607, 8388607);
        send_coords(-20000, -8388608, 8388607, -8388608, 8388607);

        // random bursts
        left = N_RANDOM;
        while (left > 0) begin
            burst = ($urandom_range(9) == 0) ? $urandom_range(80, 30) : $urandom_range(24, 1);
            if (burst > left) burst = left;
            repeat (burst) send_point(random_job());
            left = left - burst;
            in_ch.valid = 1'b0;
            gap = ($urandom_range(9) < 3) ? 0 : $urandom_range(6, 1);
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid = 1'b0;

        while (pending != 0) @(negedge i_clk);
        repeat (LATENCY + 10) @(negedge i_clk);
        if (mismatches == 0 && pending == 0) begin
            $display("rotate_point_about_center_top: match");
        end else begin
            $display("rotate_point_about_center_top: mismatch");
        end
        $finish;
    end

endmodule
